[rtl/core/iwm_pkg.sv]
// Shared types and constants for the I2C write master waveform generator.
// No dependencies; used by every module under rtl/core.
package iwm_pkg;

   // request codes carried on req_type; the fourth code is unused
   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_SEND  = 2'd1,
      REQ_STOP  = 2'd2
   } req_code_type;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLAVE_ADDRESS    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_STOP_TICKS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RISE_TICKS       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_CLOCK_TICKS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_TICKS       = 3'd4;

   localparam int unsigned ADDR_W  = 7;
   localparam int unsigned TICKS_W = 8;
   localparam int unsigned BYTE_W  = 8;

   localparam logic [ADDR_W-1:0]  RST_SLAVE_ADDRESS    = 7'h3C;
   localparam logic [TICKS_W-1:0] RST_START_STOP_TICKS = 8'd1;
   localparam logic [TICKS_W-1:0] RST_RISE_TICKS       = 8'd0;
   localparam logic [TICKS_W-1:0] RST_HALF_CLOCK_TICKS = 8'd1;
   localparam logic [TICKS_W-1:0] RST_IDLE_TICKS       = 8'd3;

   // a frame is eight data bits plus the acknowledge clock
   localparam int unsigned FRAME_BITS = BYTE_W + 1;
   localparam int unsigned BITCNT_W   = $clog2(FRAME_BITS);
   localparam logic [BITCNT_W-1:0] BITCNT_LAST = BITCNT_W'(FRAME_BITS - 1);

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [ADDR_W-1:0]  slave_address;
      logic [TICKS_W-1:0] start_stop_ticks;
      logic [TICKS_W-1:0] rise_ticks;
      logic [TICKS_W-1:0] half_clock_ticks;
      logic [TICKS_W-1:0] idle_ticks;
   } cfg_type;

   typedef struct packed {
      req_code_type      kind;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   // front to queue
   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } q_wr_type;

   // queue to back
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_rd_type;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_START_A   = 9'b000000010,
      ST_START_B   = 9'b000000100,
      ST_BIT_SETUP = 9'b000001000,
      ST_BIT_HIGH  = 9'b000010000,
      ST_BIT_LOW   = 9'b000100000,
      ST_STOP_A    = 9'b001000000,
      ST_STOP_B    = 9'b010000000,
      ST_STOP_C    = 9'b100000000
   } back_state_type;

endpackage

[rtl/core/i2c_write_master_waveform.sv]
// I2C write master waveform generator: start/send/stop requests in, line events out.
// Path: a request passes a queue entry and the back-end state register to the result register.
// Throughput: one event per cycle while rsp_stall is low; send emits a frame, start two
// events and a frame, stop three; a two-entry queue takes requests while one runs.
// Reset: synchronous; registers to defaults, both lines released, queue and output empty.
module i2c_write_master_waveform (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic [iwm_pkg::BYTE_W-1:0]         req_data_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_scl_level,
   output logic                               rsp_sda_level,
   output logic [iwm_pkg::TICKS_W-1:0]        rsp_hold_ticks,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [iwm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [iwm_pkg::TICKS_W-1:0]        csr_wdata
);

   iwm_pkg::cfg_type  cfg_ff, cfg_in;
   iwm_pkg::q_wr_type q_wr;
   iwm_pkg::q_rd_type q_rd;
   logic              q_full;
   logic              q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            iwm_pkg::CSR_SLAVE_ADDRESS:
               cfg_in.slave_address = csr_wdata[iwm_pkg::ADDR_W-1:0];
            iwm_pkg::CSR_START_STOP_TICKS: cfg_in.start_stop_ticks = csr_wdata;
            iwm_pkg::CSR_RISE_TICKS:       cfg_in.rise_ticks       = csr_wdata;
            iwm_pkg::CSR_HALF_CLOCK_TICKS: cfg_in.half_clock_ticks = csr_wdata;
            iwm_pkg::CSR_IDLE_TICKS:       cfg_in.idle_ticks       = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address    <= iwm_pkg::RST_SLAVE_ADDRESS;
         cfg_ff.start_stop_ticks <= iwm_pkg::RST_START_STOP_TICKS;
         cfg_ff.rise_ticks       <= iwm_pkg::RST_RISE_TICKS;
         cfg_ff.half_clock_ticks <= iwm_pkg::RST_HALF_CLOCK_TICKS;
         cfg_ff.idle_ticks       <= iwm_pkg::RST_IDLE_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   iwm_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .q_wr          (q_wr)
   );

   iwm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_rd   (q_rd),
      .q_pop  (q_pop)
   );

   iwm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_rd           (q_rd),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_hold_ticks (rsp_hold_ticks),
      .rsp_last       (rsp_last)
   );

   // every command ends with SDA released (acknowledge clock or stop)
   a_last_sda_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_sda_level)
      else $error("final event of a command leaves SDA low");

   // a command's last event with SCL low is the acknowledge low half period
   a_last_low_half: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && !rsp_scl_level |-> rsp_hold_ticks == cfg_ff.half_clock_ticks)
      else $error("final low-clock event has wrong hold count");

   // the queue only pops an entry it holds
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_rd.valid)
      else $error("queue popped while empty");

endmodule

[rtl/core/iwm_front.sv]
// Front end: takes requests, drops the unused code and builds queue entries.
// Depends on iwm_pkg.
module iwm_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic [iwm_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                      q_full,
   output iwm_pkg::q_wr_type         q_wr
);

   logic req_accept;

   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   always_comb begin
      q_wr.push     = req_accept && (req_type != iwm_pkg::REQ_UNUSED);
      q_wr.cmd.kind = iwm_pkg::req_code_type'(req_type);
      q_wr.cmd.data = req_data_byte;
   end

endmodule

[rtl/core/iwm_queue.sv]
// Short command queue between front and back ends.
// Depends on iwm_pkg.
module iwm_queue (
   input  logic              clock,
   input  logic              reset,
   input  iwm_pkg::q_wr_type q_wr,
   output logic              q_full,
   output iwm_pkg::q_rd_type q_rd,
   input  logic              q_pop
);

   iwm_pkg::cmd_type                    entry_ff [iwm_pkg::QUEUE_DEPTH];
   logic [iwm_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [iwm_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [iwm_pkg::QCNT_W-1:0]          count_ff, count_in;

   function automatic logic [iwm_pkg::QPTR_W-1:0] ptr_next(
      input logic [iwm_pkg::QPTR_W-1:0] ptr
   );
      if (ptr == iwm_pkg::QPTR_W'(iwm_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign q_full     = (count_ff == iwm_pkg::QCNT_W'(iwm_pkg::QUEUE_DEPTH));
   assign q_rd.valid = (count_ff != '0);
   assign q_rd.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = q_wr.push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = q_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (q_wr.push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!q_wr.push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr.push) begin
         entry_ff[wr_ptr_ff] <= q_wr.cmd;
      end
   end

endmodule

[rtl/core/iwm_back.sv]
// Back end: sequences one command into line events and holds the result register.
// Depends on iwm_pkg.
module iwm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  iwm_pkg::cfg_type            cfg,
   input  iwm_pkg::q_rd_type           q_rd,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_scl_level,
   output logic                        rsp_sda_level,
   output logic [iwm_pkg::TICKS_W-1:0] rsp_hold_ticks,
   output logic                        rsp_last
);

   iwm_pkg::back_state_type              state_ff, state_in;
   logic [iwm_pkg::FRAME_BITS-1:0]       shift_ff, shift_in;
   logic [iwm_pkg::BITCNT_W-1:0]         bitcnt_ff, bitcnt_in;
   logic                                 scl_now_ff, scl_now_in;
   logic                                 sda_now_ff, sda_now_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_scl_ff, rsp_scl_in;
   logic                                 rsp_sda_ff, rsp_sda_in;
   logic [iwm_pkg::TICKS_W-1:0]          rsp_hold_ff, rsp_hold_in;
   logic                                 rsp_last_ff, rsp_last_in;

   logic                                 out_free;
   logic                                 emit_en;
   logic                                 ev_scl, ev_sda, ev_last;
   logic [iwm_pkg::TICKS_W-1:0]          ev_hold;
   logic                                 cmd_done;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit_en  = (state_ff != iwm_pkg::ST_IDLE) && out_free;
   assign cmd_done = emit_en && ev_last;
   assign q_pop    = q_rd.valid && ((state_ff == iwm_pkg::ST_IDLE) || cmd_done);

   // event for the current step
   always_comb begin
      ev_scl  = scl_now_ff;
      ev_sda  = sda_now_ff;
      ev_hold = cfg.half_clock_ticks;
      ev_last = 1'b0;
      unique case (state_ff)
         iwm_pkg::ST_IDLE: begin
         end
         iwm_pkg::ST_START_A: begin
            ev_sda  = 1'b0;
            ev_hold = cfg.start_stop_ticks;
         end
         iwm_pkg::ST_START_B: begin
            ev_scl = 1'b0;
         end
         iwm_pkg::ST_BIT_SETUP: begin
            ev_sda  = shift_ff[iwm_pkg::FRAME_BITS-1];
            ev_hold = cfg.rise_ticks;
         end
         iwm_pkg::ST_BIT_HIGH: begin
            ev_scl = 1'b1;
         end
         iwm_pkg::ST_BIT_LOW: begin
            ev_scl  = 1'b0;
            ev_last = (bitcnt_ff == iwm_pkg::BITCNT_LAST);
         end
         iwm_pkg::ST_STOP_A: begin
            ev_sda  = 1'b0;
            ev_hold = cfg.rise_ticks;
         end
         iwm_pkg::ST_STOP_B: begin
            ev_scl  = 1'b1;
            ev_hold = cfg.start_stop_ticks;
         end
         iwm_pkg::ST_STOP_C: begin
            ev_sda  = 1'b1;
            ev_hold = cfg.idle_ticks;
            ev_last = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      shift_in   = shift_ff;
      bitcnt_in  = bitcnt_ff;
      scl_now_in = scl_now_ff;
      sda_now_in = sda_now_ff;

      if (emit_en) begin
         scl_now_in = ev_scl;
         sda_now_in = ev_sda;
         unique case (state_ff)
            iwm_pkg::ST_START_A:   state_in = iwm_pkg::ST_START_B;
            iwm_pkg::ST_START_B:   state_in = iwm_pkg::ST_BIT_SETUP;
            iwm_pkg::ST_BIT_SETUP: state_in = iwm_pkg::ST_BIT_HIGH;
            iwm_pkg::ST_BIT_HIGH:  state_in = iwm_pkg::ST_BIT_LOW;
            iwm_pkg::ST_BIT_LOW: begin
               state_in  = iwm_pkg::ST_BIT_SETUP;
               bitcnt_in = bitcnt_ff + 1'b1;
               shift_in  = {shift_ff[iwm_pkg::FRAME_BITS-2:0], 1'b1};
            end
            iwm_pkg::ST_STOP_A:    state_in = iwm_pkg::ST_STOP_B;
            iwm_pkg::ST_STOP_B:    state_in = iwm_pkg::ST_STOP_C;
            iwm_pkg::ST_STOP_C:    state_in = iwm_pkg::ST_IDLE;
            default:               state_in = iwm_pkg::ST_IDLE;
         endcase
         if (cmd_done) begin
            state_in = iwm_pkg::ST_IDLE;
         end
      end

      // next command follows straight on, no bubble
      if (q_pop) begin
         bitcnt_in = '0;
         unique case (q_rd.cmd.kind)
            iwm_pkg::REQ_START: begin
               state_in = iwm_pkg::ST_START_A;
               shift_in = {cfg.slave_address, 1'b0, 1'b1};
            end
            iwm_pkg::REQ_SEND: begin
               state_in = iwm_pkg::ST_BIT_SETUP;
               shift_in = {q_rd.cmd.data, 1'b1};
            end
            iwm_pkg::REQ_STOP: begin
               state_in = iwm_pkg::ST_STOP_A;
            end
            default: begin
               state_in = iwm_pkg::ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_scl_in   = rsp_scl_ff;
      rsp_sda_in   = rsp_sda_ff;
      rsp_hold_in  = rsp_hold_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = emit_en;
         rsp_scl_in   = ev_scl;
         rsp_sda_in   = ev_sda;
         rsp_hold_in  = ev_hold;
         rsp_last_in  = ev_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iwm_pkg::ST_IDLE;
         scl_now_ff   <= 1'b1;
         sda_now_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scl_now_ff   <= scl_now_in;
         sda_now_ff   <= sda_now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      bitcnt_ff   <= bitcnt_in;
      rsp_scl_ff  <= rsp_scl_in;
      rsp_sda_ff  <= rsp_sda_in;
      rsp_hold_ff <= rsp_hold_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_level  = rsp_scl_ff;
   assign rsp_sda_level  = rsp_sda_ff;
   assign rsp_hold_ticks = rsp_hold_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
